FILE: sv/arm_homing_position_controller_core_macros.svh
// Assertion macros for the arm homing position controller.
// Used by the checker; depends on nothing else.
`ifndef ARM_HOMING_POSITION_CONTROLLER_CORE_MACROS_SVH
`define ARM_HOMING_POSITION_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define AHPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define AHPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ahpc_pkg.sv
// Shared types and constants for the arm homing position controller.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ahpc_pkg;

	// Default length of the first homing phase, in ticks
	localparam int unsigned PHASE_TICKS_DEF = 20;
	// Phase-one skip: count jumps to this multiple of the phase length
	localparam int unsigned PHASE_SKIP_MULT = 10;

	localparam logic [6:0] PWM_STOP = 7'd100;

	// Request codes
	localparam logic [1:0] REQ_TICK       = 2'd0;
	localparam logic [1:0] REQ_SET_TARGET = 2'd1;
	localparam logic [1:0] REQ_HOME       = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOMING_SPEED  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HOME_TARGET   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HOME_FIRST_UP = 3'd5;
	localparam int unsigned CFG_DATA_W = 16;

	// Register reset values
	localparam logic [7:0]         DEADBAND_RST      = 8'd15;
	localparam logic [6:0]         MIN_SPEED_RST     = 7'd15;
	localparam logic [6:0]         MAX_SPEED_RST     = 7'd50;
	localparam logic [6:0]         HOMING_SPEED_RST  = 7'd20;
	localparam logic signed [15:0] HOME_TARGET_RST   = -16'sd256;
	localparam logic               HOME_FIRST_UP_RST = 1'b1;

	typedef enum logic [1:0] {
		HS_NOT_HOMED = 2'd0,
		HS_HOMING    = 2'd1,
		HS_HOMED     = 2'd2
	} home_state_t;

	typedef struct packed {
		logic [7:0]         deadband;
		logic [6:0]         min_speed;
		logic [6:0]         max_speed;
		logic [6:0]         homing_speed;
		logic signed [15:0] home_target;
		logic               home_first_up;
	} cfg_t;

endpackage

`default_nettype wire

FILE: sv/ahpc_intf.sv
// Channel interfaces of the arm homing position controller: request,
// result and configuration write. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface ahpc_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [15:0] encoder_position;
	logic               limit_up;
	logic               limit_back;
	logic signed [15:0] target_position;

	modport source(output valid, req_type, encoder_position, limit_up, limit_back,
		target_position, input ready);
	modport sink(input valid, req_type, encoder_position, limit_up, limit_back,
		target_position, output ready);
endinterface

interface ahpc_rsp_if;
	logic       valid;
	logic       ready;
	logic [6:0] pwm_compare;
	logic       direction_up;
	logic       brake_on;
	logic       encoder_clear;
	logic [1:0] home_status;

	modport source(output valid, pwm_compare, direction_up, brake_on, encoder_clear,
		home_status, input ready);
	modport sink(input valid, pwm_compare, direction_up, brake_on, encoder_clear,
		home_status, output ready);
endinterface

interface ahpc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] wdata;

	modport source(output valid, index, wdata, input ready);
	modport sink(input valid, index, wdata, output ready);
endinterface

`default_nettype wire

FILE: sv/arm_homing_position_controller_core.sv
// Arm homing position controller, top level. Depends on ahpc_pkg,
// the channel interfaces and ahpc_cfg_regs.
`timescale 1ns / 1ps
`default_nettype none

// One request per clock is accepted unless rsp.ready stalls the output, and
// every request yields one result. A request is captured in an input
// register, evaluated against the homing and drive state in one
// combinational pass, and its result lands in an output register once
// that register is free. The input and output registers are the only
// buffering: while a result waits, the input register can still take one
// request, and requests stop only when both hold an unread entry.
// Configuration writes must be issued while no request is in flight.
module arm_homing_position_controller_core #(
	parameter int unsigned PHASE_TICKS = ahpc_pkg::PHASE_TICKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ahpc_req_if.sink    req,
	ahpc_rsp_if.source  rsp,
	ahpc_cfg_if.sink    cfg
);

	localparam logic [7:0] PHASE_LIMIT = 8'(PHASE_TICKS);
	localparam logic [7:0] SKIP_COUNT  = 8'((ahpc_pkg::PHASE_SKIP_MULT * PHASE_TICKS) % 256);

	// Saturating inverted PWM: 100 minus speed, never below zero
	function automatic logic [6:0] inv_pwm(input logic [6:0] speed);
		inv_pwm = (speed > ahpc_pkg::PWM_STOP) ? 7'd0 : ahpc_pkg::PWM_STOP - speed;
	endfunction

	ahpc_pkg::cfg_t regs;

	ahpc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Input register
	logic               valid_s1;
	logic [1:0]         req_type_s1;
	logic signed [15:0] pos_s1;
	logic               lim_up_s1;
	logic               lim_back_s1;
	logic signed [15:0] tgt_s1;

	// Output register
	logic       out_valid_q;
	logic [6:0] out_pwm_q;
	logic       out_dir_q;
	logic       out_brake_q;
	logic       out_clr_q;
	logic [1:0] out_status_q;

	// Controller state
	ahpc_pkg::home_state_t home_state_q, home_state_d;
	logic [7:0]            count_q, count_d;
	logic signed [15:0]    target_q, target_d;
	logic [6:0]            pwm_q, pwm_d;
	logic                  dir_q, dir_d;
	logic                  brake_q, brake_d;
	logic                  clr;

	logic advance;
	logic fire_s1;

	assign advance   = !out_valid_q || rsp.ready;
	assign fire_s1   = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			pos_s1      <= req.encoder_position;
			lim_up_s1   <= req.limit_up;
			lim_back_s1 <= req.limit_back;
			tgt_s1      <= req.target_position;
		end
	end

	// Position error to clamped speed, used while homed
	logic signed [16:0] err;
	logic [15:0]        mag;
	logic [13:0]        spd_raw;
	logic [13:0]        spd_lo;
	logic [6:0]         spd;
	logic signed [16:0] db_pos;
	logic signed [16:0] db_neg;

	always_comb begin
		err     = 17'(target_q) - 17'(pos_s1);
		mag     = err[16] ? 16'(-err) : err[15:0];
		spd_raw = mag[15:2];
		// lower clamp first, then upper clamp
		spd_lo  = (spd_raw < 14'(regs.min_speed)) ? 14'(regs.min_speed) : spd_raw;
		spd     = (spd_lo > 14'(regs.max_speed)) ? regs.max_speed : spd_lo[6:0];
		db_pos  = signed'({9'd0, regs.deadband});
		db_neg  = -db_pos;
	end

	// Homing count step, saturating at all ones
	logic [7:0] cnt_inc;
	assign cnt_inc = (count_q != 8'hFF) ? count_q + 8'd1 : count_q;

	// Next state
	always_comb begin
		home_state_d = home_state_q;
		count_d      = count_q;
		target_d     = target_q;
		pwm_d        = pwm_q;
		dir_d        = dir_q;
		brake_d      = brake_q;
		clr          = 1'b0;
		unique case (req_type_s1)
			ahpc_pkg::REQ_TICK: begin
				unique case (home_state_q)
					ahpc_pkg::HS_NOT_HOMED: begin
						count_d = 8'd0;
					end
					ahpc_pkg::HS_HOMING: begin
						brake_d = 1'b0;
						count_d = cnt_inc;
						pwm_d   = inv_pwm(regs.homing_speed);
						if (cnt_inc <= PHASE_LIMIT) begin
							// phase one: configured direction, up switch ends it early
							dir_d = regs.home_first_up;
							if (lim_up_s1) begin
								count_d = SKIP_COUNT;
							end
						end else begin
							// phase two: reverse until the back switch closes
							dir_d = ~regs.home_first_up;
							if (lim_back_s1) begin
								clr          = 1'b1;
								target_d     = regs.home_target;
								home_state_d = ahpc_pkg::HS_HOMED;
							end
						end
					end
					ahpc_pkg::HS_HOMED: begin
						if (err > db_pos) begin
							dir_d   = 1'b0;
							pwm_d   = inv_pwm(spd);
							brake_d = 1'b0;
						end else if (err < db_neg) begin
							dir_d   = 1'b1;
							pwm_d   = inv_pwm(spd);
							brake_d = 1'b0;
						end else begin
							pwm_d   = ahpc_pkg::PWM_STOP;
							brake_d = 1'b1;
						end
					end
					default: ;
				endcase
			end
			ahpc_pkg::REQ_SET_TARGET: begin
				target_d = tgt_s1;
				brake_d  = 1'b0;
			end
			ahpc_pkg::REQ_HOME: begin
				home_state_d = ahpc_pkg::HS_HOMING;
				count_d      = 8'd0;
			end
			default: ; // unused code: no change
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_state_q <= ahpc_pkg::HS_NOT_HOMED;
			count_q      <= 8'd0;
			target_q     <= 16'sd0;
			pwm_q        <= ahpc_pkg::PWM_STOP;
			dir_q        <= 1'b0;
			brake_q      <= 1'b1;
		end else if (fire_s1) begin
			home_state_q <= home_state_d;
			count_q      <= count_d;
			target_q     <= target_d;
			pwm_q        <= pwm_d;
			dir_q        <= dir_d;
			brake_q      <= brake_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_pwm_q    <= pwm_d;
			out_dir_q    <= dir_d;
			out_brake_q  <= brake_d;
			out_clr_q    <= clr;
			out_status_q <= home_state_d;
		end
	end

	// Result outputs
	always_comb begin
		rsp.valid         = out_valid_q;
		rsp.pwm_compare   = out_pwm_q;
		rsp.direction_up  = out_dir_q;
		rsp.brake_on      = out_brake_q;
		rsp.encoder_clear = out_clr_q;
		rsp.home_status   = out_status_q;
	end

endmodule

`default_nettype wire

FILE: sv/ahpc_cfg_regs.sv
// Configuration register file of the arm homing position controller.
// Depends on ahpc_pkg and ahpc_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module ahpc_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	ahpc_cfg_if.sink          cfg,
	output ahpc_pkg::cfg_t    regs
);

	// Writes are always accepted
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.deadband      <= ahpc_pkg::DEADBAND_RST;
			regs.min_speed     <= ahpc_pkg::MIN_SPEED_RST;
			regs.max_speed     <= ahpc_pkg::MAX_SPEED_RST;
			regs.homing_speed  <= ahpc_pkg::HOMING_SPEED_RST;
			regs.home_target   <= ahpc_pkg::HOME_TARGET_RST;
			regs.home_first_up <= ahpc_pkg::HOME_FIRST_UP_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ahpc_pkg::CFG_DEADBAND:      regs.deadband      <= cfg.wdata[7:0];
				ahpc_pkg::CFG_MIN_SPEED:     regs.min_speed     <= cfg.wdata[6:0];
				ahpc_pkg::CFG_MAX_SPEED:     regs.max_speed     <= cfg.wdata[6:0];
				ahpc_pkg::CFG_HOMING_SPEED:  regs.homing_speed  <= cfg.wdata[6:0];
				ahpc_pkg::CFG_HOME_TARGET:   regs.home_target   <= signed'(cfg.wdata);
				ahpc_pkg::CFG_HOME_FIRST_UP: regs.home_first_up <= cfg.wdata[0];
				default: ; // unmapped index: write dropped
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/ahpc_checker.sv
// Port-level checks for the arm homing position controller, bound to the
// top level. Depends on ahpc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "arm_homing_position_controller_core_macros.svh"

module ahpc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [6:0] pwm_compare,
	input logic       encoder_clear,
	input logic [1:0] home_status
);

	// Encoder clear comes only with the result that completes homing
	`AHPC_ASSERT_NOW(a_clr_homed, clk, arst_n, rsp_valid && encoder_clear, home_status == 2'(ahpc_pkg::HS_HOMED), "encoder clear without homed status")

	// Inverted duty never exceeds the stop value
	`AHPC_ASSERT_NOW(a_pwm_range, clk, arst_n, rsp_valid, pwm_compare <= ahpc_pkg::PWM_STOP, "pwm compare above stop value")

	// A stalled result stays put
	`AHPC_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(pwm_compare) && $stable(home_status), "stalled result changed")

endmodule

bind arm_homing_position_controller_core ahpc_checker u_ahpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.pwm_compare   (rsp.pwm_compare),
	.encoder_clear (rsp.encoder_clear),
	.home_status   (rsp.home_status)
);

`default_nettype wire
